@@ rtl/lru_record_cache_assert.svh @@
// Assertion macros shared by the LRU record cache RTL.
// Standalone header; expects a clk and an active-high rst in the including scope.
`ifndef LRU_RECORD_CACHE_ASSERT_SVH
`define LRU_RECORD_CACHE_ASSERT_SVH

// Same-cycle property, disabled while in reset.
`define LRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lrc_pkg.sv @@
// Package for the LRU record cache: sizes, register map, FSM states, cell control types.
// No dependencies.
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int ENTRIES     = 64;
  localparam int HANDLE_BITS = 16;
  localparam int ID_W        = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CAP_W       = $clog2(ENTRIES + 1);
  localparam int CFG_W       = 7;
  localparam int ADDR_W      = 2;
  localparam int DATA_W      = 32;

  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             compare;
    logic             hit_move;
    logic             insert;
    logic             shrink;
    logic [CAP_W-1:0] capacity;
  } cell_ctl_t;

  // What the far end of the cell chain reports back.
  typedef struct packed {
    logic                   any_hit;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic                   any_tail;
    logic [ID_W-1:0]        tail_id;
  } chain_res_t;

endpackage

@@ rtl/lrc_cell.sv @@
// One recency slot of the LRU record cache chain: valid, id, handle and a match flag.
// Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  lrc_pkg::cell_ctl_t             ctl,
  input  logic [lrc_pkg::IDX_W-1:0]      pos,
  input  logic [lrc_pkg::ID_W-1:0]       key,
  input  logic                           prev_valid,
  input  logic [lrc_pkg::ID_W-1:0]       prev_id,
  input  logic [lrc_pkg::HANDLE_BITS-1:0] prev_handle,
  input  logic                           match_ge_in,
  input  logic [lrc_pkg::HANDLE_BITS-1:0] hit_handle_in,
  input  logic                           tail_in,
  input  logic [lrc_pkg::ID_W-1:0]       tail_id_in,
  output logic                           valid,
  output logic [lrc_pkg::ID_W-1:0]       id,
  output logic [lrc_pkg::HANDLE_BITS-1:0] handle,
  output logic                           match_ge_out,
  output logic [lrc_pkg::HANDLE_BITS-1:0] hit_handle_out,
  output logic                           tail_out,
  output logic [lrc_pkg::ID_W-1:0]       tail_id_out
);

  logic                            entry_valid;
  logic [lrc_pkg::ID_W-1:0]        entry_id;
  logic [lrc_pkg::HANDLE_BITS-1:0] entry_handle;
  logic                            match;
  logic                            beyond;
  logic                            tail;
  logic                            shift;
  logic                            load;

  // beyond: slot index at or past capacity; tail: last slot the capacity allows, when it holds a valid entry
  assign beyond = lrc_pkg::CAP_W'(pos) >= ctl.capacity;
  assign tail   = entry_valid &&
                  ((lrc_pkg::CAP_W'(pos) + lrc_pkg::CAP_W'(1)) == ctl.capacity);

  assign match_ge_out   = match | match_ge_in;
  assign hit_handle_out = hit_handle_in | (match ? entry_handle : '0);
  assign tail_out       = tail | tail_in;
  assign tail_id_out    = tail_id_in | (tail ? entry_id : '0);

  // on a hit, slots up to and including the hit slot take their neighbor's entry
  assign shift = ctl.hit_move && match_ge_out;
  assign load  = shift || ctl.insert;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      match       <= 1'b0;
    end else begin
      if (ctl.compare) begin
        match <= entry_valid && (entry_id == key);
      end
      if (ctl.shrink && beyond) begin
        entry_valid <= 1'b0;
      end else if (shift) begin
        entry_valid <= prev_valid;
      end else if (ctl.insert) begin
        entry_valid <= prev_valid && !beyond;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_id     <= prev_id;
      entry_handle <= prev_handle;
    end
  end

  assign valid  = entry_valid;
  assign id     = entry_id;
  assign handle = entry_handle;

endmodule

@@ rtl/lrc_ctrl.sv @@
// Request sequencer and result register of the LRU record cache.
// Depends on lrc_pkg and lru_record_cache_assert.svh.
`timescale 1ns / 1ps
`include "lru_record_cache_assert.svh"

module lrc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrc_pkg::ID_W-1:0]        lookup_id,
  input  logic                            decode_ok,
  input  logic [lrc_pkg::HANDLE_BITS-1:0] new_handle,
  input  logic [lrc_pkg::CAP_W-1:0]       capacity,
  input  logic                            cfg_we,
  input  logic [lrc_pkg::CAP_W-1:0]       cap_new,
  input  lrc_pkg::chain_res_t             res,
  output lrc_pkg::cell_ctl_t              ctl,
  output logic [lrc_pkg::ID_W-1:0]        head_id,
  output logic [lrc_pkg::HANDLE_BITS-1:0] head_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic                            hit,
  output logic [lrc_pkg::HANDLE_BITS-1:0] handle,
  output logic                            evicted,
  output logic [lrc_pkg::ID_W-1:0]        evicted_id
);

  lrc_pkg::state_t                 state;
  lrc_pkg::state_t                 state_next;
  logic                            commit;
  logic                            insert;
  logic                            accept;
  logic [lrc_pkg::ID_W-1:0]        req_id;
  logic                            req_ok;
  logic [lrc_pkg::HANDLE_BITS-1:0] req_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      lrc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = lrc_pkg::S_UPD;
        end
      end
      lrc_pkg::S_UPD: begin
        commit = !out_valid || out_ready;
        if (commit) begin
          state_next = lrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lrc_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;
  assign insert = commit && !res.any_hit && req_ok && (capacity != '0);

  always_comb begin
    ctl          = '0;
    ctl.compare  = accept;
    ctl.hit_move = commit && res.any_hit;
    ctl.insert   = insert;
    ctl.shrink   = cfg_we;
    ctl.capacity = cfg_we ? cap_new : capacity;
  end

  assign head_id     = req_id;
  assign head_handle = res.any_hit ? res.hit_handle : req_handle;

  // request payload, held while the cells resolve the lookup
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id     <= lookup_id;
      req_ok     <= decode_ok;
      req_handle <= new_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found      <= res.any_hit || req_ok;
      hit        <= res.any_hit;
      handle     <= res.any_hit ? res.hit_handle : (req_ok ? req_handle : '0);
      evicted    <= insert && res.any_tail;
      evicted_id <= (insert && res.any_tail) ? res.tail_id : '0;
    end
  end

  `LRC_ASSERT_NEXT(a_accept_to_upd, accept, state == lrc_pkg::S_UPD, "no update after accept")
  `LRC_ASSERT_NEXT(a_commit_loads, commit, out_valid, "commit did not present a result")
  `LRC_ASSERT(a_evict_is_insert, (out_valid && evicted) |-> (found && !hit), "bad eviction")
  `LRC_ASSERT(a_miss_fail_zero, (out_valid && !found) |-> (handle == '0 && !evicted), "fail not 0")

endmodule

@@ rtl/lru_record_cache.sv @@
// LRU record cache top level: configuration port, cell chain and request controller.
// Depends on lrc_pkg, lrc_cell, lrc_ctrl.
`timescale 1ns / 1ps

// Fully associative LRU cache of record handles keyed by a 32-bit record id,
// built as a chain of lrc_pkg::ENTRIES cells ordered by recency: cell 0 holds
// the most recent entry and the valid entries always form a prefix of the
// chain. The accept cycle compares lookup_id against every cell in parallel
// and registers a match flag per cell; the update state (S_UPD) then shifts
// the chain (a hit pulls its entry to cell 0, a cached miss pushes every
// entry down one cell and drops the tail) and loads the result register.
// The next item is accepted once the controller is back in idle, so the
// block takes no new item before the previous one has been committed;
// with the result register still full the update waits until it drains.
// The capacity register lives at byte address 0; a write saturates at
// ENTRIES and in the same cycle invalidates every cell at or past the new
// capacity (those drops are not reported as evictions). Capacity zero
// turns caching off: successful misses still return their handle.
// Writes must only be issued while no item is in flight.
module lru_record_cache (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrc_pkg::ID_W-1:0]        lookup_id,
  input  logic                            decode_ok,
  input  logic [lrc_pkg::HANDLE_BITS-1:0] new_handle,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic                            hit,
  output logic [lrc_pkg::HANDLE_BITS-1:0] handle,
  output logic                            evicted,
  output logic [lrc_pkg::ID_W-1:0]        evicted_id,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrc_pkg::ADDR_W-1:0]      paddr,
  input  logic [lrc_pkg::DATA_W-1:0]      pwdata,
  output logic [lrc_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  logic [lrc_pkg::CAP_W-1:0]       capacity;
  logic [lrc_pkg::CAP_W-1:0]       cap_new;
  logic [lrc_pkg::CFG_W-1:0]       wr_val;
  logic                            cfg_we;

  lrc_pkg::cell_ctl_t              ctl;
  lrc_pkg::chain_res_t             res;
  logic [lrc_pkg::ID_W-1:0]        head_id;
  logic [lrc_pkg::HANDLE_BITS-1:0] head_handle;

  // per-cell entry outputs (feed the next cell down)
  logic                            cell_valid  [lrc_pkg::ENTRIES];
  logic [lrc_pkg::ID_W-1:0]        cell_id     [lrc_pkg::ENTRIES];
  logic [lrc_pkg::HANDLE_BITS-1:0] cell_handle [lrc_pkg::ENTRIES];

  // reduction chains, running from the tail cell toward cell 0
  logic                            match_ge   [lrc_pkg::ENTRIES+1];
  logic [lrc_pkg::HANDLE_BITS-1:0] hit_handle [lrc_pkg::ENTRIES+1];
  logic                            tail_any   [lrc_pkg::ENTRIES+1];
  logic [lrc_pkg::ID_W-1:0]        tail_id    [lrc_pkg::ENTRIES+1];

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == lrc_pkg::ADDR_CAPACITY);
  assign wr_val = pwdata[lrc_pkg::CFG_W-1:0];

  always_comb begin
    if (int'(wr_val) > lrc_pkg::ENTRIES) begin
      cap_new = lrc_pkg::CAP_W'(lrc_pkg::ENTRIES);
    end else begin
      cap_new = lrc_pkg::CAP_W'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cap_new;
    end
  end

  assign prdata = (paddr == lrc_pkg::ADDR_CAPACITY) ? lrc_pkg::DATA_W'(capacity) : '0;

  // ---- cell chain ----
  assign match_ge[lrc_pkg::ENTRIES]   = 1'b0;
  assign hit_handle[lrc_pkg::ENTRIES] = '0;
  assign tail_any[lrc_pkg::ENTRIES]   = 1'b0;
  assign tail_id[lrc_pkg::ENTRIES]    = '0;

  for (genvar gi = 0; gi < lrc_pkg::ENTRIES; gi++) begin : g_cell
    logic                            prev_valid;
    logic [lrc_pkg::ID_W-1:0]        prev_id;
    logic [lrc_pkg::HANDLE_BITS-1:0] prev_handle;

    // cell 0 is fed the entry becoming most recent
    if (gi == 0) begin : g_head
      assign prev_valid  = 1'b1;
      assign prev_id     = head_id;
      assign prev_handle = head_handle;
    end else begin : g_body
      assign prev_valid  = cell_valid[gi-1];
      assign prev_id     = cell_id[gi-1];
      assign prev_handle = cell_handle[gi-1];
    end

    lrc_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl            (ctl),
      .pos            (lrc_pkg::IDX_W'(gi)),
      .key            (lookup_id),
      .prev_valid     (prev_valid),
      .prev_id        (prev_id),
      .prev_handle    (prev_handle),
      .match_ge_in    (match_ge[gi+1]),
      .hit_handle_in  (hit_handle[gi+1]),
      .tail_in        (tail_any[gi+1]),
      .tail_id_in     (tail_id[gi+1]),
      .valid          (cell_valid[gi]),
      .id             (cell_id[gi]),
      .handle         (cell_handle[gi]),
      .match_ge_out   (match_ge[gi]),
      .hit_handle_out (hit_handle[gi]),
      .tail_out       (tail_any[gi]),
      .tail_id_out    (tail_id[gi])
    );
  end

  // chain ends at cell 0: any match anywhere, its handle, and the tail entry
  assign res.any_hit    = match_ge[0];
  assign res.hit_handle = hit_handle[0];
  assign res.any_tail   = tail_any[0];
  assign res.tail_id    = tail_id[0];

  // ---- request sequencing and result register ----
  lrc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lookup_id   (lookup_id),
    .decode_ok   (decode_ok),
    .new_handle  (new_handle),
    .capacity    (capacity),
    .cfg_we      (cfg_we),
    .cap_new     (cap_new),
    .res         (res),
    .ctl         (ctl),
    .head_id     (head_id),
    .head_handle (head_handle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .hit         (hit),
    .handle      (handle),
    .evicted     (evicted),
    .evicted_id  (evicted_id)
  );

endmodule
